// ===== rtl/mtb_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer bank package
// Shared constants, mode codes and the per-timer update control struct.
// ----------------------------------------------------------------------------
package mtb_pkg;

	localparam int NUM_TIMERS_DEF  = 8;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int OPCODE_W = 1;
	localparam int INDEX_W  = 3;
	localparam int MODE_W   = 2;
	localparam int RELOAD_W = 16;
	localparam int MASK_W   = 8;

	localparam logic [OPCODE_W-1:0] OP_TICK  = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b1;

	localparam logic [MODE_W-1:0] MODE_STOP  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_START = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RESET = 2'd3;

	typedef struct packed {
		logic set_we;
		logic cnt_we;
		logic fire;
	} upd_ctl_t;

endpackage

// ===== rtl/mtb_ram.sv =====
// ----------------------------------------------------------------------------
// Timer bank generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/mtb_unit.sv =====
// ----------------------------------------------------------------------------
// Timer bank update unit
// Shared next-state logic for one timer: mode step, fire test and decrement.
// ----------------------------------------------------------------------------
module mtb_unit #(
	parameter int COUNT_WIDTH = mtb_pkg::COUNT_WIDTH_DEF
) (
	input  logic [mtb_pkg::MODE_W-1:0] mode,
	input  logic                       restart,
	input  logic [COUNT_WIDTH-1:0]     reload,
	input  logic [COUNT_WIDTH-1:0]     count,
	output logic [mtb_pkg::MODE_W-1:0] new_mode,
	output logic [COUNT_WIDTH-1:0]     new_count,
	output mtb_pkg::upd_ctl_t          ctl
);

	import mtb_pkg::*;

	logic                   zero;
	logic [COUNT_WIDTH-1:0] base;

	assign zero = (count == '0);

	always_comb begin
		new_mode   = mode;
		base       = count;
		ctl.set_we = 1'b0;
		ctl.cnt_we = 1'b0;
		ctl.fire   = 1'b0;
		case (mode)
			MODE_RUN: begin
				ctl.cnt_we = 1'b1;
				if (zero) begin
					ctl.fire = 1'b1;
					if (restart) begin
						base = reload;
					end else begin
						new_mode   = MODE_STOP;
						ctl.set_we = 1'b1;
					end
				end
			end
			MODE_START: begin
				base       = reload;
				new_mode   = MODE_RUN;
				ctl.set_we = 1'b1;
				ctl.cnt_we = 1'b1;
			end
			MODE_RESET: begin
				new_mode   = MODE_START;
				ctl.set_we = 1'b1;
			end
			default: begin
				new_mode = mode;
			end
		endcase
	end

	// A start loads the reload value as is; only a running timer decrements.
	assign new_count = (mode == MODE_RUN) ? COUNT_WIDTH'(base - COUNT_WIDTH'(1)) : base;

endmodule

// ===== rtl/multi_timer_bank_tick.sv =====
// ----------------------------------------------------------------------------
// Multi timer bank with tick
// Bank of down-counting timers with auto reload, one shared update unit.
// ----------------------------------------------------------------------------
//  channel | signals                                           | direction
//  in      | in_valid, in_stall, opcode, timer_index,          | request in
//          | timer_mode, reload_value, auto_restart            |
//  out     | out_valid, out_stall, expired_mask                | request out
//
// A write request produces no result.
// A tick request raises its result once every timer has been updated: the
// shared update unit visits one timer per cycle, in the cycle after its
// registered RAM read, and the finish state waits for the last update. The
// next request can be taken in the same cycle as the result is raised.
// Timer state lives in RAMs; per-entry valid bits cleared by reset make the
// bank read as stopped and zero after reset.
// A stalled result holds the finished tick, and the next tick waits at its end
// until that result is taken; no request is taken while it waits.
// ----------------------------------------------------------------------------
module multi_timer_bank_tick #(
	parameter int NUM_TIMERS  = mtb_pkg::NUM_TIMERS_DEF,
	parameter int COUNT_WIDTH = mtb_pkg::COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mtb_pkg::OPCODE_W-1:0] opcode,
	input  logic [mtb_pkg::INDEX_W-1:0]  timer_index,
	input  logic [mtb_pkg::MODE_W-1:0]   timer_mode,
	input  logic [mtb_pkg::RELOAD_W-1:0] reload_value,
	input  logic                         auto_restart,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mtb_pkg::MASK_W-1:0]   expired_mask
);

	import mtb_pkg::*;

	localparam int IW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int XW    = ((IW > INDEX_W) ? IW : INDEX_W) + 1;
	localparam int SET_W = MODE_W + 1 + COUNT_WIDTH;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]             state_q;
	logic [IW-1:0]          rd_idx_q;
	logic                   pv_s1;
	logic [IW-1:0]          idx_s1;
	logic [NUM_TIMERS-1:0]  set_vld_q;
	logic [NUM_TIMERS-1:0]  cnt_vld_q;
	logic [MASK_W-1:0]      mask_q;
	logic                   out_vld_q;
	logic [MASK_W-1:0]      out_mask_q;

	logic                   in_acc;
	logic                   wr_acc;
	logic                   tick_acc;
	logic [IW-1:0]          wr_idx;
	logic                   fin_go;

	logic                   set_we;
	logic [IW-1:0]          set_waddr;
	logic [SET_W-1:0]       set_wdata;
	logic [SET_W-1:0]       set_rdata;
	logic [COUNT_WIDTH-1:0] cnt_rdata;

	logic [MODE_W-1:0]      mode_rd;
	logic                   restart_rd;
	logic [COUNT_WIDTH-1:0] reload_rd;
	logic [COUNT_WIDTH-1:0] count_rd;
	logic [MODE_W-1:0]      new_mode;
	logic [COUNT_WIDTH-1:0] new_count;
	upd_ctl_t               ctl;
	logic [XW-1:0]          idx_x;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign wr_acc    = in_acc && (opcode == OP_WRITE)
		&& (32'(timer_index) < NUM_TIMERS);
	assign tick_acc  = in_acc && (opcode == OP_TICK);
	assign wr_idx    = IW'(timer_index);
	assign fin_go    = (state_q == ST_FIN) && !pv_s1 && (!out_vld_q || !out_stall);

	// Entries never written read as the reset value: stopped, zero.
	always_comb begin
		if (set_vld_q[idx_s1]) begin
			{mode_rd, restart_rd, reload_rd} = set_rdata;
		end else begin
			mode_rd    = MODE_STOP;
			restart_rd = 1'b0;
			reload_rd  = '0;
		end
		count_rd = cnt_vld_q[idx_s1] ? cnt_rdata : '0;
	end

	mtb_unit #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_unit (
		.mode     (mode_rd),
		.restart  (restart_rd),
		.reload   (reload_rd),
		.count    (count_rd),
		.new_mode (new_mode),
		.new_count(new_count),
		.ctl      (ctl)
	);

	assign set_we    = wr_acc || (pv_s1 && ctl.set_we);
	assign set_waddr = pv_s1 ? idx_s1 : wr_idx;
	assign set_wdata = pv_s1 ? {new_mode, restart_rd, reload_rd}
		: {timer_mode, auto_restart, COUNT_WIDTH'(reload_value)};

	mtb_ram #(
		.WIDTH(SET_W),
		.DEPTH(NUM_TIMERS)
	) u_set_ram (
		.clk  (clk),
		.we   (set_we),
		.waddr(set_waddr),
		.wdata(set_wdata),
		.raddr(rd_idx_q),
		.rdata(set_rdata)
	);

	mtb_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(NUM_TIMERS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (pv_s1 && ctl.cnt_we),
		.waddr(idx_s1),
		.wdata(new_count),
		.raddr(rd_idx_q),
		.rdata(cnt_rdata)
	);

	assign idx_x = XW'(idx_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_idx_q  <= '0;
			pv_s1     <= 1'b0;
			set_vld_q <= '0;
			cnt_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			pv_s1 <= (state_q == ST_SCAN);
			if (wr_acc) begin
				set_vld_q[wr_idx] <= 1'b1;
			end
			if (pv_s1 && ctl.cnt_we) begin
				cnt_vld_q[idx_s1] <= 1'b1;
			end
			if (fin_go) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_acc) begin
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_FIN;
					end else begin
						rd_idx_q <= rd_idx_q + IW'(1);
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (tick_acc) begin
			mask_q <= '0;
		end else if (pv_s1 && ctl.fire && (idx_x < XW'(MASK_W))) begin
			mask_q[idx_x[INDEX_W-1:0]] <= 1'b1;
		end
		if (fin_go) begin
			out_mask_q <= mask_q;
		end
	end

	assign out_valid    = out_vld_q;
	assign expired_mask = out_mask_q;

	a_s1_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s1 |-> $past(state_q == ST_SCAN))
		else $error("update stage active without a scan cycle before it");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the finish state");

	a_cnt_needs_set: assert property (@(posedge clk) disable iff (!arst_n)
		(pv_s1 && ctl.cnt_we) |-> set_vld_q[idx_s1])
		else $error("count written for a timer that was never set up");

	a_fire_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(pv_s1 && ctl.fire) |-> (mode_rd == MODE_RUN && count_rd == '0))
		else $error("timer fired outside run mode or with nonzero count");

endmodule
